>>> rtl/core/kpl_pkg.sv
// ----------------------------------------------------------------------------
// kpl_pkg
// Shared types and constants for the keypad PIN entry lock: key codes,
// result event codes, ladder thresholds and the key classifier.
// ----------------------------------------------------------------------------
package kpl_pkg;

   localparam int unsigned LEVEL_W = 10;
   localparam int unsigned DIGIT_W = 4;
   localparam int unsigned PIN_W   = 16;

   // resistor ladder thresholds
   localparam logic [LEVEL_W-1:0] LVL_RIGHT  = 10'd50;
   localparam logic [LEVEL_W-1:0] LVL_UP     = 10'd150;
   localparam logic [LEVEL_W-1:0] LVL_DOWN   = 10'd300;
   localparam logic [LEVEL_W-1:0] LVL_LEFT   = 10'd600;
   localparam logic [LEVEL_W-1:0] LVL_SELECT = 10'd900;

   localparam logic [DIGIT_W-1:0] DIGIT_BLANK = 4'd10;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 4'd9;
   localparam logic [PIN_W-1:0]   PIN_RESET   = 16'h1973;

   typedef enum logic [2:0] {
      KEY_NONE   = 3'd0,
      KEY_RIGHT  = 3'd1,
      KEY_UP     = 3'd2,
      KEY_DOWN   = 3'd3,
      KEY_LEFT   = 3'd4,
      KEY_SELECT = 3'd5
   } key_type;

   typedef enum logic [1:0] {
      EVT_NONE     = 2'd0,
      EVT_ACCEPT   = 2'd1,
      EVT_REJECT   = 2'd2,
      EVT_RELOCK   = 2'd3
   } evt_type;

   function automatic key_type classify_key(input logic [LEVEL_W-1:0] level);
      key_type key;
      if (level < LVL_RIGHT) begin
         key = KEY_RIGHT;
      end else if (level < LVL_UP) begin
         key = KEY_UP;
      end else if (level < LVL_DOWN) begin
         key = KEY_DOWN;
      end else if (level < LVL_LEFT) begin
         key = KEY_LEFT;
      end else if (level < LVL_SELECT) begin
         key = KEY_SELECT;
      end else begin
         key = KEY_NONE;
      end
      return key;
   endfunction

endpackage

>>> rtl/core/keypad_pin_entry_lock_core.sv
// ----------------------------------------------------------------------------
// keypad_pin_entry_lock_core
// PIN entry lock driven by key presses from a resistor-ladder keypad.
// ----------------------------------------------------------------------------
// Each request is one key press, given as a 10-bit ladder level. The level is
// classified into right, up, down, left, select or none. While locked, up and
// down step the digit under the cursor (0..9, wrapping), right and left move
// the cursor, and select at the last position checks the entry against
// csr_pin_code (BCD, first digit in the top nibble). A match opens the lock, a
// mismatch blanks the entry. While open, only select relocks. Every request
// gives exactly one response with the lock state, the key, the cursor and the
// digits shown. A request is registered on entry and its response is
// registered when the response register is free or being taken, so a
// stalled response holds the request; one request can be taken every cycle
// while responses are taken, and the limit is the update of the entry state.
// Write the PIN only while no request is in flight.
module keypad_pin_entry_lock_core #(
   parameter int unsigned PIN_DIGITS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [kpl_pkg::PIN_W-1:0]     csr_pin_code,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [kpl_pkg::LEVEL_W-1:0]   req_key_level,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_lock_open,
   output logic [2:0]                    rsp_key_code,
   output logic [1:0]                    rsp_cursor_pos,
   output logic [kpl_pkg::DIGIT_W-1:0]   rsp_shown_digit_0,
   output logic [kpl_pkg::DIGIT_W-1:0]   rsp_shown_digit_1,
   output logic [kpl_pkg::DIGIT_W-1:0]   rsp_shown_digit_2,
   output logic [kpl_pkg::DIGIT_W-1:0]   rsp_shown_digit_3,
   output logic [1:0]                    rsp_event_code
);
   import kpl_pkg::*;

   localparam int unsigned CUR_W = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
   localparam logic [CUR_W-1:0] CUR_LAST = CUR_W'(PIN_DIGITS - 1);
   localparam int unsigned SHOWN = 4;

   logic [PIN_W-1:0]   pin_ff;

   logic               in_valid_ff;
   logic [LEVEL_W-1:0] in_level_ff;
   logic               advance;

   logic               unlocked_ff, unlocked_in;
   logic [CUR_W-1:0]   cursor_ff, cursor_in;
   logic [DIGIT_W-1:0] edit_ff, edit_in;
   logic [DIGIT_W-1:0] entry_ff [PIN_DIGITS];
   logic [DIGIT_W-1:0] entry_in [PIN_DIGITS];

   key_type            key;
   evt_type            evt;
   logic [DIGIT_W-1:0] shown_in [SHOWN];

   logic               rsp_valid_ff;
   logic               lock_open_ff;
   logic [2:0]         key_code_ff;
   logic [1:0]         cursor_pos_ff;
   logic [DIGIT_W-1:0] shown_ff [SHOWN];
   logic [1:0]         event_code_ff;

   // expected nibble for entry position k; digits beyond the register are 0
   function automatic logic [DIGIT_W-1:0] pin_nibble(input logic [PIN_W-1:0] pin,
                                                     input int unsigned k);
      int unsigned sh;
      logic [PIN_W-1:0] tmp;
      sh  = DIGIT_W * (PIN_DIGITS - 1 - k);
      tmp = (sh < PIN_W) ? (pin >> sh) : '0;
      return tmp[DIGIT_W-1:0];
   endfunction

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      logic check;
      logic match;
      key         = classify_key(in_level_ff);
      evt         = EVT_NONE;
      unlocked_in = unlocked_ff;
      cursor_in   = cursor_ff;
      edit_in     = edit_ff;
      entry_in    = entry_ff;
      check       = 1'b0;
      match       = 1'b1;
      if (unlocked_ff) begin
         if (key == KEY_SELECT) begin
            unlocked_in = 1'b0;
            cursor_in   = '0;
            edit_in     = '0;
            for (int k = 0; k < PIN_DIGITS; k++) entry_in[k] = DIGIT_BLANK;
            evt = EVT_RELOCK;
         end
      end else begin
         case (key)
            KEY_UP: begin
               edit_in = (edit_ff < DIGIT_MAX) ? edit_ff + 4'd1 : 4'd0;
            end
            KEY_DOWN: begin
               edit_in = (edit_ff > 4'd0) ? edit_ff - 4'd1 : DIGIT_MAX;
            end
            KEY_RIGHT: begin
               if (cursor_ff < CUR_LAST) begin
                  cursor_in = cursor_ff + 1'b1;
                  edit_in   = '0;
               end
            end
            KEY_LEFT: begin
               if (cursor_ff != '0) begin
                  // leaving digit is stored; recall the one to the left
                  entry_in[cursor_ff] = edit_ff;
                  cursor_in           = cursor_ff - 1'b1;
                  edit_in             = entry_ff[cursor_in];
               end
            end
            KEY_SELECT: begin
               check = (cursor_ff == CUR_LAST);
            end
            default: begin
            end
         endcase
         // digit under the cursor always follows the edit digit
         entry_in[cursor_ff] = (key == KEY_RIGHT) ? edit_ff : entry_in[cursor_ff];
         entry_in[cursor_in] = edit_in;
         for (int k = 0; k < PIN_DIGITS; k++) begin
            if (entry_in[k] != pin_nibble(pin_ff, k)) match = 1'b0;
         end
         if (check) begin
            if (match) begin
               unlocked_in = 1'b1;
               evt         = EVT_ACCEPT;
            end else begin
               cursor_in = '0;
               edit_in   = '0;
               for (int k = 0; k < PIN_DIGITS; k++) entry_in[k] = DIGIT_BLANK;
               evt = EVT_REJECT;
            end
         end
      end
      for (int k = 0; k < SHOWN; k++) begin
         shown_in[k] = (k < PIN_DIGITS) ? entry_in[k] : DIGIT_BLANK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_ff       <= PIN_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         unlocked_ff  <= 1'b0;
         cursor_ff    <= '0;
         edit_ff      <= '0;
         for (int k = 0; k < PIN_DIGITS; k++) entry_ff[k] <= DIGIT_BLANK;
      end else begin
         if (csr_valid && csr_ready) pin_ff <= csr_pin_code;
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            unlocked_ff  <= unlocked_in;
            cursor_ff    <= cursor_in;
            edit_ff      <= edit_in;
            entry_ff     <= entry_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_level_ff <= req_key_level;
      if (advance) begin
         lock_open_ff  <= unlocked_in;
         key_code_ff   <= key;
         cursor_pos_ff <= 2'(cursor_in);
         shown_ff      <= shown_in;
         event_code_ff <= evt;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_lock_open     = lock_open_ff;
   assign rsp_key_code      = key_code_ff;
   assign rsp_cursor_pos    = cursor_pos_ff;
   assign rsp_shown_digit_0 = shown_ff[0];
   assign rsp_shown_digit_1 = shown_ff[1];
   assign rsp_shown_digit_2 = shown_ff[2];
   assign rsp_shown_digit_3 = shown_ff[3];
   assign rsp_event_code    = event_code_ff;

endmodule

>>> rtl/core/kpl_checker.sv
// ----------------------------------------------------------------------------
// kpl_checker
// Port-level checks for the keypad PIN entry lock, bound to the core.
// ----------------------------------------------------------------------------
module kpl_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_lock_open,
   input logic [2:0]                  rsp_key_code,
   input logic [1:0]                  rsp_cursor_pos,
   input logic [kpl_pkg::DIGIT_W-1:0] rsp_shown_digit_0,
   input logic [kpl_pkg::DIGIT_W-1:0] rsp_shown_digit_1,
   input logic [kpl_pkg::DIGIT_W-1:0] rsp_shown_digit_2,
   input logic [kpl_pkg::DIGIT_W-1:0] rsp_shown_digit_3,
   input logic [1:0]                  rsp_event_code
);
   import kpl_pkg::*;

   logic entry_blank;
   assign entry_blank = rsp_cursor_pos == 2'd0 &&
                        rsp_shown_digit_0 == DIGIT_BLANK &&
                        rsp_shown_digit_1 == DIGIT_BLANK &&
                        rsp_shown_digit_2 == DIGIT_BLANK &&
                        rsp_shown_digit_3 == DIGIT_BLANK;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code) &&
         $stable(rsp_lock_open) && $stable(rsp_shown_digit_0))
      else $error("response changed while stalled");

   a_evt_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code != EVT_NONE |-> rsp_key_code == KEY_SELECT)
      else $error("lock event without select key");

   a_accept_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == EVT_ACCEPT |-> rsp_lock_open)
      else $error("accepted PIN but lock closed");

   a_clear_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == EVT_REJECT || rsp_event_code == EVT_RELOCK)
         |-> !rsp_lock_open && entry_blank)
      else $error("reject or relock left entry or lock state");

endmodule

bind keypad_pin_entry_lock_core kpl_checker u_kpl_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_lock_open     (rsp_lock_open),
   .rsp_key_code      (rsp_key_code),
   .rsp_cursor_pos    (rsp_cursor_pos),
   .rsp_shown_digit_0 (rsp_shown_digit_0),
   .rsp_shown_digit_1 (rsp_shown_digit_1),
   .rsp_shown_digit_2 (rsp_shown_digit_2),
   .rsp_shown_digit_3 (rsp_shown_digit_3),
   .rsp_event_code    (rsp_event_code)
);

>>> sim/tb_keypad_pin_entry_lock_core.sv
// ----------------------------------------------------------------------------
// tb_keypad_pin_entry_lock_core
// Self-checking bench for the keypad PIN entry lock core. Key presses are
// sent as ladder levels in random bursts, and a behavioral copy of the lock
// predicts every response. The bench walks through several PIN settings,
// mostly with goal-directed code entry and some random key noise.
// ----------------------------------------------------------------------------
module tb_keypad_pin_entry_lock_core;
   timeunit 1ns;
   timeprecision 1ps;

   import kpl_pkg::*;

   localparam logic [LEVEL_W-1:0] LEVEL_TOP = '1;
   localparam int LONG_HOLD_CYCLES = 40;
   localparam int DRAIN_CYCLES     = 4;
   localparam int PHASE_PRESSES    = 70;
   localparam longint TIMEOUT_NS   = 2_000_000;

   typedef struct packed {
      logic                    lock_open;
      key_type                 key;
      logic [1:0]              cursor;
      logic [3:0][DIGIT_W-1:0] digits;
      evt_type                 evt;
   } lock_snapshot_type;

   class pin_lock_model;
      localparam logic [1:0] LAST_POS = 2'd3;

      logic [PIN_W-1:0]        pin;
      logic                    unlocked;
      logic [1:0]              cursor;
      logic [DIGIT_W-1:0]      edit;
      logic [3:0][DIGIT_W-1:0] digits;
      evt_type                 last_evt;
      lock_snapshot_type       pending_snapshots[$];
      int                      mismatch_count;

      function new();
         pin = PIN_RESET;
         unlocked = 1'b0;
         last_evt = EVT_NONE;
         mismatch_count = 0;
         clear_entry();
      endfunction

      function void clear_entry();
         digits = {4{DIGIT_BLANK}};
         cursor = '0;
         edit = '0;
      endfunction

      function lock_snapshot_type apply_press(logic [LEVEL_W-1:0] level);
         key_type           key;
         evt_type           evt;
         bit                check;
         lock_snapshot_type snap;
         evt = EVT_NONE;
         check = 1'b0;
         if (level < LVL_RIGHT) begin
            key = KEY_RIGHT;
         end else if (level < LVL_UP) begin
            key = KEY_UP;
         end else if (level < LVL_DOWN) begin
            key = KEY_DOWN;
         end else if (level < LVL_LEFT) begin
            key = KEY_LEFT;
         end else if (level < LVL_SELECT) begin
            key = KEY_SELECT;
         end else begin
            key = KEY_NONE;
         end
         if (unlocked) begin
            if (key == KEY_SELECT) begin
               unlocked = 1'b0;
               clear_entry();
               evt = EVT_RELOCK;
            end
         end else begin
            case (key)
               KEY_UP: begin
                  edit = (edit == DIGIT_MAX) ? '0 : edit + 1'b1;
               end
               KEY_DOWN: begin
                  edit = (edit == '0) ? DIGIT_MAX : edit - 1'b1;
               end
               KEY_RIGHT: begin
                  if (cursor != LAST_POS) begin
                     digits[cursor] = edit;
                     cursor = cursor + 1'b1;
                     edit = '0;
                  end
               end
               KEY_LEFT: begin
                  if (cursor != '0) begin
                     digits[cursor] = edit;
                     cursor = cursor - 1'b1;
                     edit = digits[cursor];
                  end
               end
               KEY_SELECT: begin
                  check = (cursor == LAST_POS);
               end
               default: ;
            endcase
            // the digit under the cursor is always shown
            digits[cursor] = edit;
            if (check) begin
               if ({digits[0], digits[1], digits[2], digits[3]} == pin) begin
                  unlocked = 1'b1;
                  evt = EVT_ACCEPT;
               end else begin
                  clear_entry();
                  evt = EVT_REJECT;
               end
            end
         end
         last_evt = evt;
         snap.lock_open = unlocked;
         snap.key = key;
         snap.cursor = cursor;
         snap.digits = digits;
         snap.evt = evt;
         return snap;
      endfunction

      function void note_press(logic [LEVEL_W-1:0] level);
         pending_snapshots.push_back(apply_press(level));
      endfunction

      function void check_snapshot(lock_snapshot_type got);
         lock_snapshot_type want;
         if (pending_snapshots.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("%0t: response with no request pending", $time);
            end
            mismatch_count++;
            return;
         end
         want = pending_snapshots.pop_front();
         if (got.lock_open !== want.lock_open || got.key !== want.key ||
             got.cursor !== want.cursor || got.digits[0] !== want.digits[0] ||
             got.digits[1] !== want.digits[1] || got.digits[2] !== want.digits[2] ||
             got.digits[3] !== want.digits[3] || got.evt !== want.evt) begin
            if (mismatch_count < 10) begin
               $display({"%0t: mismatch expected open=%0d key=%0d pos=%0d ",
                         "digits=%0d,%0d,%0d,%0d event=%0d"},
                        $time, want.lock_open, want.key, want.cursor, want.digits[0],
                        want.digits[1], want.digits[2], want.digits[3], want.evt);
               $display({"%0t: mismatch actual   open=%0d key=%0d pos=%0d ",
                         "digits=%0d,%0d,%0d,%0d event=%0d"},
                        $time, got.lock_open, got.key, got.cursor, got.digits[0],
                        got.digits[1], got.digits[2], got.digits[3], got.evt);
            end
            mismatch_count++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [PIN_W-1:0]     csr_pin_code;
   logic                 req_valid;
   logic                 req_ready;
   logic [LEVEL_W-1:0]   req_key_level;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_lock_open;
   logic [2:0]           rsp_key_code;
   logic [1:0]           rsp_cursor_pos;
   logic [DIGIT_W-1:0]   rsp_shown_digit_0;
   logic [DIGIT_W-1:0]   rsp_shown_digit_1;
   logic [DIGIT_W-1:0]   rsp_shown_digit_2;
   logic [DIGIT_W-1:0]   rsp_shown_digit_3;
   logic [1:0]           rsp_event_code;

   pin_lock_model lock_model = new();
   int            presses_sent = 0;
   int            burst_left = 0;
   bit            hold_responses = 1'b0;

   keypad_pin_entry_lock_core #(
      .PIN_DIGITS(4)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_pin_code      (csr_pin_code),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_key_level     (req_key_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_lock_open     (rsp_lock_open),
      .rsp_key_code      (rsp_key_code),
      .rsp_cursor_pos    (rsp_cursor_pos),
      .rsp_shown_digit_0 (rsp_shown_digit_0),
      .rsp_shown_digit_1 (rsp_shown_digit_1),
      .rsp_shown_digit_2 (rsp_shown_digit_2),
      .rsp_shown_digit_3 (rsp_shown_digit_3),
      .rsp_event_code    (rsp_event_code)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [LEVEL_W-1:0] level_of(key_type key);
      case (key)
         KEY_RIGHT:  return LEVEL_W'($urandom_range(0, LVL_RIGHT - 1));
         KEY_UP:     return LEVEL_W'($urandom_range(LVL_RIGHT, LVL_UP - 1));
         KEY_DOWN:   return LEVEL_W'($urandom_range(LVL_UP, LVL_DOWN - 1));
         KEY_LEFT:   return LEVEL_W'($urandom_range(LVL_DOWN, LVL_LEFT - 1));
         KEY_SELECT: return LEVEL_W'($urandom_range(LVL_LEFT, LVL_SELECT - 1));
         default:    return LEVEL_W'($urandom_range(LVL_SELECT, LEVEL_TOP));
      endcase
   endfunction

   // called and returns at a falling edge; valid stays up for the next press
   task automatic press_key(input logic [LEVEL_W-1:0] level);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid = 1'b1;
      req_key_level = level;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      lock_model.note_press(level);
      presses_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (lock_model.pending_snapshots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_pin(input logic [PIN_W-1:0] value);
      csr_valid = 1'b1;
      csr_pin_code = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      lock_model.pin = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // steers the lock toward a code, with some random keys mixed in
   task automatic enter_code(input logic [3:0][DIGIT_W-1:0] code, input int noise_pct);
      int      steps;
      int      k;
      int      up_dist;
      bit      stale;
      key_type key;
      steps = 0;
      while (steps < 60) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            key = key_type'($urandom_range(0, 5));
         end else if (lock_model.unlocked) begin
            key = KEY_SELECT;
         end else begin
            stale = 1'b0;
            for (k = 0; k < int'(lock_model.cursor); k++) begin
               if (lock_model.digits[k] != code[k]) stale = 1'b1;
            end
            up_dist = (int'(code[lock_model.cursor]) - int'(lock_model.edit) + 10) % 10;
            if (stale) begin
               key = KEY_LEFT;
            end else if (up_dist != 0) begin
               if ($urandom_range(0, 3) == 0) begin
                  key = $urandom_range(0, 1) ? KEY_UP : KEY_DOWN;
               end else begin
                  key = (up_dist <= 5) ? KEY_UP : KEY_DOWN;
               end
            end else if (lock_model.cursor != 2'd3) begin
               key = KEY_RIGHT;
            end else begin
               key = KEY_SELECT;
            end
         end
         press_key(level_of(key));
         steps++;
         if (lock_model.last_evt == EVT_ACCEPT) begin
            repeat ($urandom_range(0, 4)) press_key(level_of(key_type'($urandom_range(0, 4))));
            press_key(level_of(KEY_SELECT));
            break;
         end
         if (lock_model.last_evt == EVT_REJECT) break;
      end
   endtask

   task automatic exercise_lock(input int presses);
      int                      stop_at;
      int                      k;
      int                      pick;
      logic [3:0][DIGIT_W-1:0] code;
      stop_at = presses_sent + presses;
      while (presses_sent < stop_at) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) press_key(LEVEL_W'($urandom_range(0, LEVEL_TOP)));
         end else begin
            pick = $urandom_range(0, 9);
            for (k = 0; k < 4; k++) begin
               code[k] = lock_model.pin[4 * (3 - k) +: 4];
               if (code[k] > DIGIT_MAX) code[k] = DIGIT_W'($urandom_range(0, 9));
            end
            if (pick == 6 || pick == 7) begin
               code[2'($urandom_range(0, 3))] = DIGIT_W'($urandom_range(0, 9));
            end else if (pick >= 8) begin
               for (k = 0; k < 4; k++) code[k] = DIGIT_W'($urandom_range(0, 9));
            end
            enter_code(code, $urandom_range(0, 15));
         end
      end
   endtask

   // response side: steady and choppy stretches, plus one long hold on request
   initial begin
      int stall_left;
      int mode_left;
      bit choppy;
      rsp_ready = 1'b0;
      stall_left = 0;
      mode_left = 0;
      choppy = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_responses) begin
            rsp_ready = 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
            hold_responses = 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if (mode_left == 0) begin
               choppy = $urandom_range(0, 1);
               mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (choppy && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 5);
         end
      end
   end

   always @(posedge clock) begin
      lock_snapshot_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.lock_open = rsp_lock_open;
         got.key = key_type'(rsp_key_code);
         got.cursor = rsp_cursor_pos;
         got.digits = {rsp_shown_digit_3, rsp_shown_digit_2, rsp_shown_digit_1,
                       rsp_shown_digit_0};
         got.evt = evt_type'(rsp_event_code);
         lock_model.check_snapshot(got);
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic [LEVEL_W-1:0] directed_levels [25];
      logic [PIN_W-1:0]   phase_pins [6];
      int                 n;
      // enter the reset PIN 1-9-7-3 with ignored keys along the way, use the
      // open lock, relock, then a wrong entry of all zeros
      directed_levels = '{LVL_LEFT - 10'd1, LVL_SELECT - 10'd1, LEVEL_TOP, LVL_RIGHT,
                          10'd0, LVL_UP, LVL_RIGHT - 10'd1, LVL_DOWN - 10'd1, 10'd200,
                          10'd250, 10'd10, LVL_UP - 10'd1, 10'd100, 10'd60, 10'd20,
                          LVL_LEFT, 10'd100, LVL_SELECT, LVL_DOWN, 10'd0,
                          10'd700, 10'd30, 10'd5, 10'd40, 10'd800};
      phase_pins[0] = 16'h0000;
      phase_pins[1] = 16'h9999;
      phase_pins[2] = 16'h8A7F;
      phase_pins[3] = 16'h6745;
      phase_pins[4] = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                       4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      phase_pins[5] = PIN_W'($urandom_range(0, 16'h9999));
      reset = 1'b1;
      req_valid = 1'b0;
      req_key_level = '0;
      csr_valid = 1'b0;
      csr_pin_code = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (n = 0; n < 25; n++) press_key(directed_levels[n]);
      exercise_lock(PHASE_PRESSES - 25);

      for (n = 0; n < 6; n++) begin
         wait_for_drain();
         write_pin(phase_pins[n]);
         // back up the block while requests keep coming
         if (n == 1) hold_responses = 1'b1;
         exercise_lock(PHASE_PRESSES);
      end

      wait_for_drain();
      if (lock_model.mismatch_count == 0 && lock_model.pending_snapshots.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
